@@ sv/cstp_pkg.sv @@
// ----------------------------------------------------------------------------
// Call stack time profiler package
// Shared constants, codes and beat types of the call stack time profiler.
// ----------------------------------------------------------------------------
package cstp_pkg;

	localparam int STACK_DEPTH_DEF = 32;
	localparam int FRAME_BITS_DEF  = 16;
	localparam int RESULT_CAP      = 32;

	localparam int ID_W     = 16;
	localparam int TIME_W   = 64;
	localparam int TDEPTH_W = 6;

	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_PROFILE_EN = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TRACE_EN   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RESUME_ID  = 2'd2;

	typedef enum logic [1:0] {
		CMD_ENTER  = 2'd0,
		CMD_LEAVE  = 2'd1,
		CMD_TAIL   = 2'd2,
		CMD_UNWIND = 2'd3
	} cmd_t;

	typedef enum logic {
		ALU_SUB_FLOOR = 1'b0,
		ALU_ADD_SAT   = 1'b1
	} alu_op_t;

	typedef struct packed {
		cmd_t                cmd;
		logic [ID_W-1:0]     entry_id;
		logic [TIME_W-1:0]   now_time;
		logic [TDEPTH_W-1:0] goal_depth;
	} item_t;

	typedef struct packed {
		logic [ID_W-1:0]     popped_frame;
		logic [ID_W-1:0]     parent_frame;
		logic                has_parent;
		logic [TIME_W-1:0]   inclusive_time;
		logic [TIME_W-1:0]   self_time;
		logic [TDEPTH_W-1:0] depth_after;
		logic                overflow;
		logic                last;
	} result_t;

endpackage

@@ sv/cstp_alu.sv @@
// ----------------------------------------------------------------------------
// Call stack time profiler shared adder
// One 64-bit adder that either subtracts with a floor at zero or adds with
// saturation at all ones.
// ----------------------------------------------------------------------------
module cstp_alu (
	input  cstp_pkg::alu_op_t          op,
	input  logic [cstp_pkg::TIME_W-1:0] a,
	input  logic [cstp_pkg::TIME_W-1:0] b,
	output logic [cstp_pkg::TIME_W-1:0] y
);
	import cstp_pkg::*;

	logic              is_sub;
	logic [TIME_W:0]   sum;

	assign is_sub = (op == ALU_SUB_FLOOR);
	assign sum = {1'b0, a} + {1'b0, (is_sub ? ~b : b)} + (TIME_W+1)'(is_sub);

	// For a subtraction the carry out means no borrow; for an addition it
	// means the sum did not fit.
	always_comb begin
		unique case (op)
			ALU_SUB_FLOOR: y = sum[TIME_W] ? sum[TIME_W-1:0] : '0;
			ALU_ADD_SAT:   y = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
			default:       y = '0;
		endcase
	end

endmodule

@@ sv/cstp_stack.sv @@
// ----------------------------------------------------------------------------
// Call stack time profiler frame store
// Frame id, entry time and child time of every stack level, one write port
// and one registered read port shared by the three arrays.
// ----------------------------------------------------------------------------
module cstp_stack #(
	parameter int STACK_DEPTH = cstp_pkg::STACK_DEPTH_DEF,
	parameter int FRAME_BITS  = cstp_pkg::FRAME_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           push_we,
	input  logic                           child_we,
	input  logic [$clog2(STACK_DEPTH)-1:0] waddr,
	input  logic [FRAME_BITS-1:0]          wframe,
	input  logic [cstp_pkg::TIME_W-1:0]    wentry,
	input  logic [cstp_pkg::TIME_W-1:0]    wchild,
	input  logic [$clog2(STACK_DEPTH)-1:0] raddr,
	output logic [FRAME_BITS-1:0]          rframe,
	output logic [cstp_pkg::TIME_W-1:0]    rentry,
	output logic [cstp_pkg::TIME_W-1:0]    rchild
);
	import cstp_pkg::*;

	logic [FRAME_BITS-1:0] frame_mem [STACK_DEPTH];
	logic [TIME_W-1:0]     entry_mem [STACK_DEPTH];
	logic [TIME_W-1:0]     child_mem [STACK_DEPTH];

	logic [FRAME_BITS-1:0] rframe_q;
	logic [TIME_W-1:0]     rentry_q;
	logic [TIME_W-1:0]     rchild_q;

	always_ff @(posedge clk) begin
		if (push_we) begin
			frame_mem[waddr] <= wframe;
			entry_mem[waddr] <= wentry;
		end
		if (push_we || child_we) begin
			child_mem[waddr] <= wchild;
		end
	end

	always_ff @(posedge clk) begin
		rframe_q <= frame_mem[raddr];
		rentry_q <= entry_mem[raddr];
		rchild_q <= child_mem[raddr];
	end

	assign rframe = rframe_q;
	assign rentry = rentry_q;
	assign rchild = rchild_q;

endmodule

@@ sv/cstp_emit.sv @@
// ----------------------------------------------------------------------------
// Call stack time profiler result stage
// Holds back one record so that the final record of a command can carry the
// last flag, and drops records beyond the per-command cap.
// ----------------------------------------------------------------------------
module cstp_emit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              rec_valid,
	input  cstp_pkg::result_t rec,
	input  logic              flush,
	output logic              result_valid,
	output cstp_pkg::result_t result
);
	import cstp_pkg::*;

	localparam int CNT_W = $clog2(RESULT_CAP + 1);

	result_t          pend_q;
	logic             pend_valid_q;
	logic [CNT_W-1:0] count_q;
	result_t          out_q;
	logic             out_valid_q;
	logic             take;
	result_t          held_mid;
	result_t          held_end;

	assign take = rec_valid && (count_q < CNT_W'(RESULT_CAP));

	always_comb begin
		held_mid      = pend_q;
		held_mid.last = 1'b0;
		held_end      = pend_q;
		held_end.last = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			count_q      <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			out_valid_q <= 1'b0;
			if (take) begin
				// A newer record exists, so the held one is not the last.
				out_valid_q  <= pend_valid_q;
				pend_valid_q <= 1'b1;
				count_q      <= count_q + CNT_W'(1);
			end else if (flush) begin
				out_valid_q  <= pend_valid_q;
				pend_valid_q <= 1'b0;
				count_q      <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			pend_q <= rec;
			out_q  <= held_mid;
		end else if (flush) begin
			out_q  <= held_end;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule

@@ sv/call_stack_time_profiler.sv @@
// ----------------------------------------------------------------------------
// Call stack time profiler
// Shadow call stack that times enter, leave, tail call and unwind commands.
// ----------------------------------------------------------------------------
// A command is taken when start is high and busy is low; busy then stays high
// until the command has finished its last step. Each pop runs its steps
// through one shared 64-bit adder (inclusive time, self time, parent credit)
// and the single read port of the frame store. Records appear on result for
// one cycle each with result_valid high. Each record is held back until the
// next one is made, so it leaves in the cycle after the step that makes the
// next record; the final record, marked last, leaves in the first cycle with
// busy low. The receiver cannot hold records off. A command ignored because
// profiling is off leaves busy low.
// ----------------------------------------------------------------------------
module call_stack_time_profiler #(
	parameter int STACK_DEPTH = cstp_pkg::STACK_DEPTH_DEF,
	parameter int FRAME_BITS  = cstp_pkg::FRAME_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [cstp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [cstp_pkg::CFG_W-1:0]       cfg_data,
	input  logic                             start,
	input  cstp_pkg::item_t                  item,
	output logic                             busy,
	output logic                             result_valid,
	output cstp_pkg::result_t                result
);
	import cstp_pkg::*;

	localparam int AW    = $clog2(STACK_DEPTH);
	localparam int LVL_W = $clog2(STACK_DEPTH + 1);
	localparam int CMP_W = (LVL_W > TDEPTH_W) ? LVL_W : TDEPTH_W;

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_NEXT   = 7'b0000010,
		S_INCL   = 7'b0000100,
		S_SELF   = 7'b0001000,
		S_CREDIT = 7'b0010000,
		S_OVF    = 7'b0100000,
		S_FLUSH  = 7'b1000000
	} state_t;

	state_t state_q;

	logic              profile_en_q;
	logic              trace_en_q;
	logic [ID_W-1:0]   resume_id_q;

	cmd_t                cmd_q;
	logic [ID_W-1:0]     id_q;
	logic [TIME_W-1:0]   now_q;
	logic [TDEPTH_W-1:0] target_q;
	logic                halt_q;
	logic                pop_done_q;
	logic [LVL_W-1:0]    level_q;

	logic [FRAME_BITS-1:0] pop_frame_q;
	logic [FRAME_BITS-1:0] par_frame_q;
	logic [TIME_W-1:0]     child_q;
	logic [TIME_W-1:0]     par_child_q;
	logic [TIME_W-1:0]     incl_q;
	logic [TIME_W-1:0]     self_q;

	logic [LVL_W-1:0] lvl_m1;
	logic [LVL_W-1:0] lvl_m2;
	logic             empty;
	logic             full;
	logic             has_parent;
	logic             lvl_gt_tgt;
	logic             lvl_lt_tgt;
	logic             do_pop;
	logic             do_push;
	logic [ID_W-1:0]  push_id;

	alu_op_t           alu_op;
	logic [TIME_W-1:0] alu_a;
	logic [TIME_W-1:0] alu_b;
	logic [TIME_W-1:0] alu_y;

	logic                  push_we;
	logic                  child_we;
	logic [AW-1:0]         waddr;
	logic [AW-1:0]         raddr;
	logic [TIME_W-1:0]     wchild;
	logic [FRAME_BITS-1:0] rframe;
	logic [TIME_W-1:0]     rentry;
	logic [TIME_W-1:0]     rchild;

	logic    rec_valid;
	result_t rec;
	logic    flush;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			profile_en_q <= 1'b0;
			trace_en_q   <= 1'b1;
			resume_id_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PROFILE_EN: profile_en_q <= cfg_data[0];
				REG_TRACE_EN:   trace_en_q   <= cfg_data[0];
				REG_RESUME_ID:  resume_id_q  <= cfg_data[ID_W-1:0];
				default: ;
			endcase
		end
	end

	assign lvl_m1     = level_q - LVL_W'(1);
	assign lvl_m2     = level_q - LVL_W'(2);
	assign empty      = (level_q == '0);
	assign full       = (level_q == LVL_W'(STACK_DEPTH));
	assign has_parent = (level_q > LVL_W'(1));
	assign lvl_gt_tgt = CMP_W'(level_q) > CMP_W'(target_q);
	assign lvl_lt_tgt = CMP_W'(level_q) < CMP_W'(target_q);
	assign push_id    = (cmd_q == CMD_UNWIND) ? resume_id_q : id_q;

	// Next action of the command; only looked at in S_NEXT.
	always_comb begin
		do_pop  = 1'b0;
		do_push = 1'b0;
		if (!halt_q) begin
			unique case (cmd_q)
				CMD_ENTER: do_push = 1'b1;
				CMD_LEAVE: do_pop = !pop_done_q && !empty;
				CMD_TAIL: begin
					do_pop  = !pop_done_q && !empty;
					do_push = pop_done_q || empty;
				end
				CMD_UNWIND: begin
					do_pop  = lvl_gt_tgt;
					do_push = lvl_lt_tgt;
				end
				default: ;
			endcase
		end
	end

	// Shared adder operands.
	always_comb begin
		alu_op = ALU_SUB_FLOOR;
		alu_a  = now_q;
		alu_b  = rentry;
		if (state_q == S_SELF) begin
			alu_a = incl_q;
			alu_b = child_q;
		end else if (state_q == S_CREDIT) begin
			alu_op = ALU_ADD_SAT;
			alu_a  = par_child_q;
			alu_b  = incl_q;
		end
	end

	cstp_alu u_alu (
		.op (alu_op),
		.a  (alu_a),
		.b  (alu_b),
		.y  (alu_y)
	);

	assign push_we  = (state_q == S_NEXT) && do_push && !full;
	assign child_we = (state_q == S_CREDIT) && trace_en_q && has_parent;
	assign waddr    = (state_q == S_CREDIT) ? lvl_m2[AW-1:0] : level_q[AW-1:0];
	assign wchild   = (state_q == S_CREDIT) ? alu_y : '0;
	// The parent entry is fetched while the inclusive time is formed.
	assign raddr    = (state_q == S_INCL) ? lvl_m2[AW-1:0] : lvl_m1[AW-1:0];

	cstp_stack #(
		.STACK_DEPTH (STACK_DEPTH),
		.FRAME_BITS  (FRAME_BITS)
	) u_stack (
		.clk      (clk),
		.push_we  (push_we),
		.child_we (child_we),
		.waddr    (waddr),
		.wframe   (FRAME_BITS'(push_id)),
		.wentry   (now_q),
		.wchild   (wchild),
		.raddr    (raddr),
		.rframe   (rframe),
		.rentry   (rentry),
		.rchild   (rchild)
	);

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			level_q    <= '0;
			halt_q     <= 1'b0;
			pop_done_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start && profile_en_q) begin
						state_q    <= S_NEXT;
						halt_q     <= 1'b0;
						pop_done_q <= 1'b0;
					end
				end
				S_NEXT: begin
					if (do_pop) begin
						state_q <= S_INCL;
					end else if (do_push && full) begin
						state_q <= S_OVF;
					end else if (do_push) begin
						level_q <= level_q + LVL_W'(1);
						if (cmd_q != CMD_UNWIND) begin
							halt_q <= 1'b1;
						end
					end else begin
						state_q <= S_FLUSH;
					end
				end
				S_INCL:   state_q <= S_SELF;
				S_SELF:   state_q <= S_CREDIT;
				S_CREDIT: begin
					level_q    <= lvl_m1;
					pop_done_q <= 1'b1;
					state_q    <= S_NEXT;
				end
				S_OVF: begin
					halt_q  <= 1'b1;
					state_q <= S_NEXT;
				end
				S_FLUSH:  state_q <= S_IDLE;
				default:  state_q <= S_IDLE;
			endcase
		end
	end

	// Command and pop datapath registers.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			cmd_q    <= item.cmd;
			id_q     <= item.entry_id;
			now_q    <= item.now_time;
			target_q <= item.goal_depth;
		end
		if (state_q == S_INCL) begin
			incl_q      <= alu_y;
			pop_frame_q <= rframe;
			child_q     <= rchild;
		end
		if (state_q == S_SELF) begin
			self_q      <= alu_y;
			par_frame_q <= rframe;
			par_child_q <= rchild;
		end
	end

	always_comb begin
		rec_valid = 1'b0;
		rec       = '0;
		if (state_q == S_CREDIT) begin
			rec_valid          = trace_en_q;
			rec.popped_frame   = ID_W'(pop_frame_q);
			rec.parent_frame   = has_parent ? ID_W'(par_frame_q) : '0;
			rec.has_parent     = has_parent;
			rec.inclusive_time = incl_q;
			rec.self_time      = self_q;
			rec.depth_after    = TDEPTH_W'(lvl_m1);
		end else if (state_q == S_OVF) begin
			rec_valid          = 1'b1;
			rec.popped_frame   = ID_W'(FRAME_BITS'(push_id));
			rec.parent_frame   = ID_W'(rframe);
			rec.has_parent     = !empty;
			rec.depth_after    = TDEPTH_W'(level_q);
			rec.overflow       = 1'b1;
		end
	end

	assign flush = (state_q == S_FLUSH);

	cstp_emit u_emit (
		.clk          (clk),
		.arst_n       (arst_n),
		.rec_valid    (rec_valid),
		.rec          (rec),
		.flush        (flush),
		.result_valid (result_valid),
		.result       (result)
	);

	assign busy = (state_q != S_IDLE);

	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		level_q <= LVL_W'(STACK_DEPTH))
		else $error("stack level beyond capacity");

	a_last_ends_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.last |-> !busy)
		else $error("final record sent while command still running");

	a_ovf_zero_time: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.overflow |->
			(result.inclusive_time == '0) && (result.self_time == '0))
		else $error("refused push record carries time");

	a_disabled_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && !profile_en_q |=> !busy && !result_valid)
		else $error("command taken while profiling is off");

endmodule
